[src/bsd_pkg.sv]
// Shared types, result codes and header constants for the BMP stream decoder.
`default_nettype none

package bsd_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam logic [1:0] RK_PIXEL  = 2'd0;
    localparam logic [1:0] RK_HEADER = 2'd1;
    localparam logic [1:0] RK_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE  = 3'd1;
    localparam logic [2:0] ERR_DIB_SMALL  = 3'd2;
    localparam logic [2:0] ERR_DEPTH      = 3'd3;
    localparam logic [2:0] ERR_COMPRESSED = 3'd4;
    localparam logic [2:0] ERR_SIZE       = 3'd5;
    localparam logic [2:0] ERR_OFFSET     = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd7;

    localparam logic [7:0]  SIG_FIRST    = 8'h42;
    localparam logic [7:0]  SIG_SECOND   = 8'h4D;
    localparam logic [31:0] HEADER_END   = 32'd54;
    localparam logic [31:0] DIB_MIN      = 32'd40;
    localparam logic [15:0] BPP_24       = 16'd24;
    localparam logic [15:0] BPP_32       = 16'd32;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } bsd_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        is_32bit;
        logic [2:0]  error_code;
        logic        last_pixel;
    } bsd_result_t;

    typedef struct packed {
        logic        produced;
        bsd_result_t result;
    } bsd_out_t;

endpackage

`default_nettype wire

[src/bsd_input_stage.sv]
// Input register that holds one byte-stream transfer for the decode stage.
`default_nettype none

module bsd_input_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_kind,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              advance,
    output logic                   item_valid,
    output bsd_pkg::bsd_item_t     item
);

    logic               valid_reg;
    bsd_pkg::bsd_item_t item_reg;

    // The register frees up in the same cycle that the decode stage consumes it.
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.kind      <= s_kind;
            item_reg.data_byte <= s_data_byte;
        end
    end

endmodule

`default_nettype wire

[src/bsd_core.sv]
// Decode stage: header parsing and checks, offset skip, pixel assembly, row padding and error results.
`default_nettype none

module bsd_core #(
    parameter int MAX_WIDTH  = bsd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bsd_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire bsd_pkg::bsd_item_t item,
    output bsd_pkg::bsd_out_t       out
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    localparam logic [5:0] POS_SIG0      = 6'd0;
    localparam logic [5:0] POS_SIG1      = 6'd1;
    localparam logic [5:0] POS_OFFSET    = 6'd13;
    localparam logic [5:0] POS_DIB       = 6'd17;
    localparam logic [5:0] POS_WIDTH     = 6'd21;
    localparam logic [5:0] POS_HEIGHT    = 6'd25;
    localparam logic [5:0] POS_DEPTH     = 6'd29;
    localparam logic [5:0] POS_COMP      = 6'd33;
    localparam logic [5:0] POS_HDR_LAST  = 6'd53;
    localparam logic [1:0] FIELD_ALIGN   = 2'd2;

    logic [2:0]    phase_reg, phase_next;
    logic [31:0]   pos_reg, pos_next;
    logic [23:0]   acc_reg, acc_next;
    logic [31:0]   pixel_start_reg, pixel_start_next;
    logic          ofs_bad_reg, ofs_bad_next;
    logic          w_bad_reg, w_bad_next;
    logic          h_bad_reg, h_bad_next;
    logic          bpp_bad_reg, bpp_bad_next;
    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic          bottom_up_reg, bottom_up_next;
    logic          is32_reg, is32_next;
    logic [WW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [1:0]    bip_reg, bip_next;
    logic [23:0]   held_reg, held_next;
    logic [1:0]    pad_reg, pad_next;

    logic [5:0]       hpos;
    logic [1:0]       lane;
    logic [7:0]       b;
    logic [31:0]      field_top;
    logic [15:0]      bpp;
    logic [31:0]      mag;
    logic [31:0]      pos_inc;
    logic [1:0]       last_idx;
    logic [1:0]       pad_new;
    logic [1:0]       pad_dec;
    logic [WW-1:0]    col_inc;
    logic [HW-1:0]    row_inc;
    logic [HW-1:0]    row_out;
    logic [WW+11:0]   col_wide;
    logic [HW+11:0]   row_wide;
    logic [WW+12:0]   width_wide;
    logic [HW+12:0]   height_wide;
    logic [WW+1:0]    width_low;
    logic             fail;
    logic [2:0]       fail_code;
    bsd_pkg::bsd_result_t res;
    logic             produced;

    assign hpos        = pos_reg[5:0];
    assign lane        = hpos[1:0] - FIELD_ALIGN;
    assign b           = item.data_byte;
    assign field_top   = {b, acc_reg};
    // The depth field starts two bytes into a four-byte lane group.
    assign bpp         = {b, acc_reg[23:16]};
    assign mag         = field_top[31] ? (~field_top + 32'd1) : field_top;
    assign pos_inc     = pos_reg + 32'd1;
    assign last_idx    = is32_reg ? 2'd3 : 2'd2;
    assign col_inc     = col_reg + WW'(1);
    assign row_inc     = row_reg + HW'(1);
    assign row_out     = bottom_up_reg ? (height_reg - row_reg - HW'(1)) : row_reg;
    assign col_wide    = {12'd0, col_reg};
    assign row_wide    = {12'd0, row_out};
    assign width_wide  = {13'd0, width_reg};
    assign height_wide = {13'd0, height_reg};
    assign width_low   = {2'd0, width_reg};
    // A 24-bit row of w pixels needs (w mod 4) padding bytes to reach a multiple of four.
    assign pad_new     = is32_reg ? 2'd0 : width_low[1:0];
    assign pad_dec     = pad_reg - 2'd1;

    always_comb begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        acc_next         = acc_reg;
        pixel_start_next = pixel_start_reg;
        ofs_bad_next     = ofs_bad_reg;
        w_bad_next       = w_bad_reg;
        h_bad_next       = h_bad_reg;
        bpp_bad_next     = bpp_bad_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        bottom_up_next   = bottom_up_reg;
        is32_next        = is32_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        bip_next         = bip_reg;
        held_next        = held_reg;
        pad_next         = pad_reg;
        fail             = 1'b0;
        fail_code        = bsd_pkg::ERR_NONE;
        produced         = 1'b0;
        res              = '0;

        priority if (phase_reg == PH_DONE || phase_reg == PH_ERROR) begin
            // Finished or failed: everything is ignored until reset.
        end else if (item.kind) begin
            fail      = 1'b1;
            fail_code = bsd_pkg::ERR_TRUNCATED;
        end else begin
            unique case (phase_reg)
                PH_HEADER: begin
                    unique case (lane)
                        2'd0: acc_next[7:0]   = b;
                        2'd1: acc_next[15:8]  = b;
                        2'd2: acc_next[23:16] = b;
                        default: ;
                    endcase
                    unique case (hpos)
                        POS_SIG0: begin
                            if (b != bsd_pkg::SIG_FIRST) begin
                                fail      = 1'b1;
                                fail_code = bsd_pkg::ERR_SIGNATURE;
                            end
                        end
                        POS_SIG1: begin
                            if (b != bsd_pkg::SIG_SECOND) begin
                                fail      = 1'b1;
                                fail_code = bsd_pkg::ERR_SIGNATURE;
                            end
                        end
                        POS_OFFSET: begin
                            pixel_start_next = field_top;
                            ofs_bad_next     = field_top < bsd_pkg::HEADER_END;
                        end
                        POS_DIB: begin
                            if (field_top < bsd_pkg::DIB_MIN) begin
                                fail      = 1'b1;
                                fail_code = bsd_pkg::ERR_DIB_SMALL;
                            end
                        end
                        POS_WIDTH: begin
                            width_next = field_top[WW-1:0];
                            w_bad_next = (field_top == 32'd0) || field_top[31] ||
                                         (field_top > 32'(MAX_WIDTH));
                        end
                        POS_HEIGHT: begin
                            height_next    = mag[HW-1:0];
                            bottom_up_next = !field_top[31];
                            h_bad_next     = (mag == 32'd0) || (mag > 32'(MAX_HEIGHT));
                        end
                        POS_DEPTH: begin
                            bpp_bad_next = (bpp != bsd_pkg::BPP_24) && (bpp != bsd_pkg::BPP_32);
                            is32_next    = (bpp == bsd_pkg::BPP_32);
                        end
                        POS_COMP: begin
                            priority if (bpp_bad_reg) begin
                                fail      = 1'b1;
                                fail_code = bsd_pkg::ERR_DEPTH;
                            end else if (field_top != 32'd0) begin
                                fail      = 1'b1;
                                fail_code = bsd_pkg::ERR_COMPRESSED;
                            end else if (w_bad_reg || h_bad_reg) begin
                                fail      = 1'b1;
                                fail_code = bsd_pkg::ERR_SIZE;
                            end else if (ofs_bad_reg) begin
                                fail      = 1'b1;
                                fail_code = bsd_pkg::ERR_OFFSET;
                            end else begin
                                produced           = 1'b1;
                                res.result_kind    = bsd_pkg::RK_HEADER;
                                res.image_width    = width_wide[12:0];
                                res.image_height   = height_wide[12:0];
                                res.is_32bit       = is32_reg;
                            end
                        end
                        default: ;
                    endcase
                    pos_next = pos_inc;
                    if (hpos == POS_HDR_LAST) begin
                        phase_next = (pixel_start_reg == bsd_pkg::HEADER_END) ?
                                     PH_PIXEL : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    pos_next = pos_inc;
                    if (pos_inc == pixel_start_reg) begin
                        phase_next = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    if (bip_reg < last_idx) begin
                        unique case (bip_reg)
                            2'd0: held_next[7:0]   = b;
                            2'd1: held_next[15:8]  = b;
                            2'd2: held_next[23:16] = b;
                            default: ;
                        endcase
                        bip_next = bip_reg + 2'd1;
                    end else begin
                        produced        = 1'b1;
                        res.result_kind = bsd_pkg::RK_PIXEL;
                        res.blue        = held_reg[7:0];
                        res.green       = held_reg[15:8];
                        res.red         = is32_reg ? held_reg[23:16] : b;
                        res.alpha       = is32_reg ? b : bsd_pkg::ALPHA_OPAQUE;
                        res.column      = col_wide[11:0];
                        res.row         = row_wide[11:0];
                        res.is_32bit    = is32_reg;
                        res.last_pixel  = (row_inc == height_reg) && (col_inc == width_reg);
                        bip_next        = 2'd0;
                        if (col_inc >= width_reg) begin
                            col_next = '0;
                            row_next = row_inc;
                            pad_next = pad_new;
                            if (pad_new != 2'd0) begin
                                phase_next = PH_PAD;
                            end else if (row_inc >= height_reg) begin
                                phase_next = PH_DONE;
                            end
                        end else begin
                            col_next = col_inc;
                        end
                    end
                end
                PH_PAD: begin
                    pad_next = pad_dec;
                    if (pad_dec == 2'd0) begin
                        phase_next = (row_reg >= height_reg) ? PH_DONE : PH_PIXEL;
                    end
                end
                default: ;
            endcase
        end

        if (fail) begin
            phase_next      = PH_ERROR;
            produced        = 1'b1;
            res             = '0;
            res.result_kind = bsd_pkg::RK_ERROR;
            res.error_code  = fail_code;
        end
    end

    assign out.produced = produced;
    assign out.result   = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            bip_reg   <= '0;
            pad_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            bip_reg   <= bip_next;
            pad_reg   <= pad_next;
        end
    end

    // Header fields and pixel bytes are always written before they are read.
    always_ff @(posedge aclk) begin
        if (advance) begin
            acc_reg         <= acc_next;
            pixel_start_reg <= pixel_start_next;
            ofs_bad_reg     <= ofs_bad_next;
            w_bad_reg       <= w_bad_next;
            h_bad_reg       <= h_bad_next;
            bpp_bad_reg     <= bpp_bad_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            bottom_up_reg   <= bottom_up_next;
            is32_reg        <= is32_next;
            held_reg        <= held_next;
        end
    end

endmodule

`default_nettype wire

[src/bsd_output_stage.sv]
// Result register that holds one result until the downstream side takes it.
`default_nettype none

module bsd_output_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire bsd_pkg::bsd_out_t out,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output bsd_pkg::bsd_result_t   result
);

    logic                 valid_reg;
    bsd_pkg::bsd_result_t result_reg;

    assign m_valid = valid_reg;
    assign result  = result_reg;

    // The decode stage only advances when this register is empty or being drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= out.produced;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && out.produced) begin
            result_reg <= out.result;
        end
    end

endmodule

`default_nettype wire

[src/bmp_stream_decoder.sv]
// Top level of the streaming 24/32-bit BMP decoder.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | s_kind, s_data_byte
//   m_      | out       | m_valid / m_ready  | m_result_kind, pixel, position, size, error
//
// One byte is taken every clock cycle unless the result register is stalled; each byte
// passes through the input register into the decode logic, which loads any result it
// produces into the result register.
// Reset is synchronous and active low and clears all control state at once.
// When m_ready is low while a result is held, the result register holds and the input
// register takes a byte only if empty; s_ready then falls until the result is transferred.
`default_nettype none

module bmp_stream_decoder #(
    parameter int MAX_WIDTH  = bsd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bsd_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic [7:0]       m_alpha,
    output logic [11:0]      m_column,
    output logic [11:0]      m_row,
    output logic [12:0]      m_image_width,
    output logic [12:0]      m_image_height,
    output logic             m_is_32bit,
    output logic [2:0]       m_error_code,
    output logic             m_last_pixel
);

    logic                 item_valid;
    logic                 advance;
    bsd_pkg::bsd_item_t   item;
    bsd_pkg::bsd_out_t    core_out;
    bsd_pkg::bsd_result_t result;

    assign advance = item_valid && (!m_valid || m_ready);

    bsd_input_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    bsd_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .out     (core_out)
    );

    bsd_output_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .out     (core_out),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .result  (result)
    );

    assign m_result_kind  = result.result_kind;
    assign m_red          = result.red;
    assign m_green        = result.green;
    assign m_blue         = result.blue;
    assign m_alpha        = result.alpha;
    assign m_column       = result.column;
    assign m_row          = result.row;
    assign m_image_width  = result.image_width;
    assign m_image_height = result.image_height;
    assign m_is_32bit     = result.is_32bit;
    assign m_error_code   = result.error_code;
    assign m_last_pixel   = result.last_pixel;

endmodule

`default_nettype wire

[src/bsd_checker.sv]
// Port-level checker for the BMP stream decoder, bound to the top level.
`default_nettype none

module bsd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_result_kind,
    input wire logic [7:0]  m_red,
    input wire logic [11:0] m_column,
    input wire logic [12:0] m_image_width,
    input wire logic [12:0] m_image_height,
    input wire logic        m_is_32bit,
    input wire logic [2:0]  m_error_code,
    input wire logic        m_last_pixel
);

    logic stopped_reg;

    // Once an error result is transferred the decoder must stay silent until reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg <= 1'b0;
        end else if (m_valid && m_ready && m_result_kind == bsd_pkg::RK_ERROR) begin
            stopped_reg <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) && $stable(m_red)
            && $stable(m_column) && $stable(m_error_code))
        else $error("result changed while stalled");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == bsd_pkg::RK_ERROR |->
            m_error_code != bsd_pkg::ERR_NONE && !m_is_32bit && !m_last_pixel)
        else $error("error result with inconsistent fields");

    a_header_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == bsd_pkg::RK_HEADER |->
            m_image_width != 13'd0 && m_image_height != 13'd0
            && m_error_code == bsd_pkg::ERR_NONE)
        else $error("header result with empty size or error code");

    a_silent_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> !m_valid)
        else $error("result after an error result");

endmodule

bind bmp_stream_decoder bsd_checker u_bsd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_kind  (m_result_kind),
    .m_red          (m_red),
    .m_column       (m_column),
    .m_image_width  (m_image_width),
    .m_image_height (m_image_height),
    .m_is_32bit     (m_is_32bit),
    .m_error_code   (m_error_code),
    .m_last_pixel   (m_last_pixel)
);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the BMP stream decoder: one random BMP file, complete or truncated.
module testbench;
    import bsd_pkg::*;

    localparam int unsigned HOLD_AT  = 250;
    localparam int unsigned HOLD_LEN = 150;
    localparam int unsigned DRAIN    = 20;

    typedef enum logic [2:0] {
        DEC_HEADER, DEC_SKIP, DEC_PIXEL, DEC_PAD, DEC_DONE, DEC_ERROR
    } dec_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_red, m_green, m_blue, m_alpha;
    logic [11:0] m_column, m_row;
    logic [12:0] m_image_width, m_image_height;
    logic        m_is_32bit;
    logic [2:0]  m_error_code;
    logic        m_last_pixel;

    bsd_item_t   file_bytes[$];
    bsd_result_t results_due[$];

    int unsigned items_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned hold_cycles = 0;
    bit          hold_armed = 1'b1;
    bit          in_taken = 1'b0;

    // Decoder state as the testbench tracks it.
    dec_phase_t  dec_phase = DEC_HEADER;
    logic [31:0] byte_pos = '0;
    logic [31:0] field_acc = '0;
    logic [31:0] field_shift = '0;
    logic [31:0] pixel_start = '0;
    logic [31:0] hdr_w = '0;
    logic [31:0] hdr_h = '0;
    logic [31:0] hdr_bpp = '0;
    logic [31:0] width_reg = '0;
    logic [31:0] height_reg = '0;
    logic        bottom_up = 1'b0;
    logic        depth32 = 1'b0;
    logic [31:0] col_cnt = '0;
    logic [31:0] row_cnt = '0;
    logic [1:0]  pix_byte = '0;
    logic [23:0] held = '0;
    logic [1:0]  pad_left = '0;

    bmp_stream_decoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_image_width  (m_image_width),
        .m_image_height (m_image_height),
        .m_is_32bit     (m_is_32bit),
        .m_error_code   (m_error_code),
        .m_last_pixel   (m_last_pixel)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void flag_error(input logic [2:0] code);
        bsd_result_t r;
        r = '0;
        r.result_kind = RK_ERROR;
        r.error_code = code;
        dec_phase = DEC_ERROR;
        results_due.push_back(r);
    endfunction

    // Advances the tracked decoder by one transferred item.
    function automatic void decode_byte(input logic kind, input logic [7:0] b);
        bsd_result_t r;
        logic [31:0] v;
        logic [31:0] mag;
        logic [31:0] row_pos;
        r = '0;
        if (dec_phase == DEC_DONE || dec_phase == DEC_ERROR) return;
        if (kind) begin
            flag_error(ERR_TRUNCATED);
            return;
        end
        case (dec_phase)
            DEC_HEADER: begin
                if ((byte_pos == 0 && b != SIG_FIRST) || (byte_pos == 1 && b != SIG_SECOND)) begin
                    flag_error(ERR_SIGNATURE);
                    return;
                end
                if (byte_pos >= 2 && byte_pos <= 33) begin
                    field_acc |= {24'd0, b} << field_shift[4:0];
                    field_shift += 8;
                    case (byte_pos)
                        5, 9, 13, 17, 21, 25, 27, 29, 33: begin
                            v = field_acc;
                            field_acc = '0;
                            field_shift = '0;
                            case (byte_pos)
                                13: pixel_start = v;
                                17: begin
                                    if (v < DIB_MIN) begin
                                        flag_error(ERR_DIB_SMALL);
                                        return;
                                    end
                                end
                                21: hdr_w = v;
                                25: hdr_h = v;
                                29: hdr_bpp = v;
                                33: begin
                                    mag = hdr_h[31] ? (~hdr_h + 32'd1) : hdr_h;
                                    if (hdr_bpp != BPP_24 && hdr_bpp != BPP_32)
                                        flag_error(ERR_DEPTH);
                                    else if (v != 0)
                                        flag_error(ERR_COMPRESSED);
                                    else if (hdr_w == 0 || hdr_w[31] || hdr_w > MAX_WIDTH_DEF)
                                        flag_error(ERR_SIZE);
                                    else if (mag == 0 || mag > MAX_HEIGHT_DEF)
                                        flag_error(ERR_SIZE);
                                    else if (pixel_start < HEADER_END)
                                        flag_error(ERR_OFFSET);
                                    if (dec_phase == DEC_ERROR) return;
                                    width_reg = hdr_w;
                                    height_reg = mag;
                                    bottom_up = !hdr_h[31];
                                    depth32 = (hdr_bpp == BPP_32);
                                    r.result_kind = RK_HEADER;
                                    r.image_width = width_reg[12:0];
                                    r.image_height = height_reg[12:0];
                                    r.is_32bit = depth32;
                                    results_due.push_back(r);
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                byte_pos += 1;
                if (byte_pos == HEADER_END)
                    dec_phase = (pixel_start == HEADER_END) ? DEC_PIXEL : DEC_SKIP;
            end
            DEC_SKIP: begin
                byte_pos += 1;
                if (byte_pos == pixel_start) dec_phase = DEC_PIXEL;
            end
            DEC_PIXEL: begin
                if (pix_byte < (depth32 ? 2'd3 : 2'd2)) begin
                    held |= {16'd0, b} << {pix_byte, 3'b000};
                    pix_byte += 2'd1;
                    return;
                end
                r.result_kind = RK_PIXEL;
                r.blue = held[7:0];
                r.green = held[15:8];
                r.red = depth32 ? held[23:16] : b;
                r.alpha = depth32 ? b : ALPHA_OPAQUE;
                row_pos = bottom_up ? (height_reg - 1 - row_cnt) : row_cnt;
                r.column = col_cnt[11:0];
                r.row = row_pos[11:0];
                r.is_32bit = depth32;
                r.last_pixel = (row_cnt + 1 == height_reg) && (col_cnt + 1 == width_reg);
                results_due.push_back(r);
                held = '0;
                pix_byte = '0;
                col_cnt += 1;
                if (col_cnt >= width_reg) begin
                    col_cnt = '0;
                    row_cnt += 1;
                    pad_left = depth32 ? 2'd0 : 2'(4 - ((width_reg * 3) & 3));
                    if (pad_left != 0) dec_phase = DEC_PAD;
                    else if (row_cnt >= height_reg) dec_phase = DEC_DONE;
                end
            end
            default: begin
                pad_left -= 2'd1;
                if (pad_left == 0)
                    dec_phase = (row_cnt >= height_reg) ? DEC_DONE : DEC_PIXEL;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic int unsigned idle_pct(input bit for_sender);
        case ((items_taken / 100) % 4)
            1: return for_sender ? 52 : 0;
            2: return for_sender ? 0 : 52;
            3: return 16;
            default: return 0;
        endcase
    endfunction

    function automatic void push_item(input logic kind, input logic [7:0] b);
        bsd_item_t it;
        it.kind = kind;
        it.data_byte = b;
        file_bytes.push_back(it);
    endfunction

    function automatic void push_le(input logic [31:0] v, input int unsigned nbytes);
        for (int i = 0; i < nbytes; i++) push_item(1'b0, v[8*i +: 8]);
    endfunction

    // Input side: a new transfer is offered only once the current one has been taken.
    always @(negedge aclk) begin : driver
        bsd_item_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (file_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                next_item = file_bytes.pop_front();
                s_valid <= 1'b1;
                s_kind <= next_item.kind;
                s_data_byte <= next_item.data_byte;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (hold_cycles == 0) && ($urandom_range(99) >= idle_pct(1'b0));
    end

    // One long receiver hold-off so that the decoder backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && items_taken >= HOLD_AT) begin
            hold_cycles <= HOLD_LEN;
            hold_armed <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(posedge aclk) begin : monitor
        bsd_result_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                decode_byte(s_kind, s_data_byte);
                items_taken <= items_taken + 1;
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, kind %0d, expected none",
                             $time, m_result_kind);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", want.result_kind, m_result_kind);
                    check_field("red", want.red, m_red);
                    check_field("green", want.green, m_green);
                    check_field("blue", want.blue, m_blue);
                    check_field("alpha", want.alpha, m_alpha);
                    check_field("column", want.column, m_column);
                    check_field("row", want.row, m_row);
                    check_field("image_width", want.image_width, m_image_width);
                    check_field("image_height", want.image_height, m_image_height);
                    check_field("is_32bit", want.is_32bit, m_is_32bit);
                    check_field("error_code", want.error_code, m_error_code);
                    check_field("last_pixel", want.last_pixel, m_last_pixel);
                end
            end
        end
    end

    initial begin
        int unsigned img_w, img_h, row_bytes, pad, gap, cut, ending, n;
        bit          is32, top_down;
        logic [31:0] dib;

        // Image geometry: small width, height chosen so the file is around 750 bytes.
        is32 = 1'($urandom_range(1));
        img_w = $urandom_range(1, 9);
        row_bytes = is32 ? 4 * img_w : (3 * img_w + 3) / 4 * 4;
        pad = row_bytes - (is32 ? 4 : 3) * img_w;
        img_h = 1 + 700 / row_bytes;
        top_down = ($urandom_range(3) == 0);
        gap = $urandom_range(6);
        dib = ($urandom_range(3) == 0) ? ($urandom | 32'h8000_0000) : 40 + $urandom_range(84);

        push_item(1'b0, SIG_FIRST);
        push_item(1'b0, SIG_SECOND);
        push_le($urandom, 4);
        push_le($urandom, 4);
        push_le(HEADER_END + gap, 4);
        push_le(dib, 4);
        push_le(img_w, 4);
        push_le(top_down ? -img_h : img_h, 4);
        push_le($urandom, 2);
        push_le(32'(is32 ? BPP_32 : BPP_24), 2);
        push_le(32'd0, 4);
        repeat (20 + gap) push_item(1'b0, 8'($urandom_range(255)));

        // The first pixel is all zeros and the second all ones.
        n = 0;
        for (int y = 0; y < img_h; y++) begin
            for (int x = 0; x < img_w; x++) begin
                for (int k = 0; k < (is32 ? 4 : 3); k++)
                    push_item(1'b0, (n == 0) ? 8'h00 : (n == 1) ? 8'hFF :
                                    8'($urandom_range(255)));
                n++;
            end
            for (int k = 0; k < pad; k++) push_item(1'b0, 8'($urandom_range(255)));
        end

        // Either a complete image with trailing data, or one cut short in its last row.
        ending = $urandom_range(3);
        if (ending >= 2) begin
            cut = (ending == 2) ? $urandom_range(1, row_bytes) : 1;
            repeat (cut) void'(file_bytes.pop_back());
        end else begin
            repeat (3) push_item(1'b0, 8'($urandom_range(255)));
        end
        push_item(1'b1, 8'($urandom_range(255)));
        repeat (2) push_item(1'b0, 8'($urandom_range(255)));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (file_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
src/bsd_pkg.sv
src/bsd_input_stage.sv
src/bsd_core.sv
src/bsd_output_stage.sv
src/bmp_stream_decoder.sv
src/bsd_checker.sv
dv/testbench.sv
